// ===== rtl/core/cost_basis_lot_matcher_assert.svh =====
// assertion macros for the cost basis lot matcher
`ifndef COST_BASIS_LOT_MATCHER_ASSERT_SVH
`define COST_BASIS_LOT_MATCHER_ASSERT_SVH
`ifndef SYNTH
`define CBLM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cost basis lot matcher check failed");
`define CBLM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cost basis lot matcher check failed");
`else
`define CBLM_ASSERT(lbl, clk, rstn, prop)
`define CBLM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/cblm_pkg.sv =====
// shared types and constants of the cost basis lot matcher
package cblm_pkg;
  localparam int MaxLotsDef = 64;
  localparam int DateW      = 20;
  localparam int SharesW    = 32;
  localparam int PriceW     = 32;
  localparam int TotSharesW = 40;
  localparam int CostW      = 64;
  localparam int ModeW      = 2;
  localparam int InDataW    = 88;
  localparam int OutDataW   = 72;

  localparam logic [ModeW-1:0] ModeFifo = 2'd0;
  localparam logic [ModeW-1:0] ModeLifo = 2'd1;
  localparam logic             FuncNew  = 1'b1;
  localparam logic             RegCostMode = 1'b0;
  localparam logic             RegCalcDate = 1'b1;

  typedef struct packed {
    logic load_in;
    logic clear;
    logic set_past;
    logic buy;
    logic add;
    logic sell_init;
    logic rd;
    logic mul_sell;
    logic sub_sell;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_new;
    logic past;
    logic late;
    logic zero;
    logic is_buy;
    logic full;
    logic avg_mode;
    logic want_zero;
    logic count_zero;
    logic div_busy;
    logic out_busy;
  } stat_t;
endpackage

// ===== rtl/core/cost_basis_lot_matcher.sv =====
// top level of the cost basis lot matcher
//
// channel   dir  tdata / payload                               tuser
// s_axis    in   [19:0] trade_date [51:20] trade_shares        [0] func
//                [83:52] trade_price, [87:84] zero
// m_axis    out  [31:0] avg_price [71:32] open_shares          [0] has_position
// cfg       in   cfg_index_i selects register, cfg_data_i value
//
// an item's time is set by the 64-step restoring divider for the average price and by the
// one-port lot memory; each lot touched by a sell goes through read, multiply and subtract states.
// reset clears totals, lot pointers and registers at once; no clearing pass.
// the next request is taken while a finished result waits on m_axis.
module cost_basis_lot_matcher import cblm_pkg::*; #(
  parameter int MaxLots = MaxLotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // trade_date, trade_shares, trade_price
  input  logic                s_axis_tuser,   // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // avg_price, open_shares
  output logic                m_axis_tuser,   // has_position
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [DateW-1:0]    cfg_data_i
);
  `include "cost_basis_lot_matcher_assert.svh"

  cmd_t                  cmd;
  stat_t                 stat;
  logic [PriceW-1:0]     avg_price;
  logic [TotSharesW-1:0] open_shares;

  assign cfg_ready_o = 1'b1;

  cblm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  cblm_dp #(.MaxLots(MaxLots)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_func_i      (s_axis_tuser),
    .in_date_i      (s_axis_tdata[19:0]),
    .in_shares_i    (s_axis_tdata[51:20]),
    .in_price_i     (s_axis_tdata[83:52]),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .avg_price_o    (avg_price),
    .has_position_o (m_axis_tuser),
    .open_shares_o  (open_shares)
  );

  assign m_axis_tdata = {open_shares, avg_price};

  `CBLM_ASSERT(a_busy_after_req, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `CBLM_ASSERT_IMP(a_flag_matches, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser == (m_axis_tdata[71:32] != 40'd0))
  `CBLM_ASSERT_IMP(a_flat_no_price, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:0] == 32'd0)
endmodule

// ===== rtl/core/cblm_ctrl.sv =====
// controller state machine sequencing buys, lot-by-lot sells and the divide
module cblm_ctrl import cblm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    StIdle, StDecide, StBuyAdd, StSellRd, StSellMul, StSellSub, StDivGo, StDivRun, StOut
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        state_d = StDivGo;
        if (stat_i.is_new) begin
          cmd_o.clear = 1'b1;
        end else if (stat_i.past) begin
          state_d = StDivGo;
        end else if (stat_i.late) begin
          cmd_o.set_past = 1'b1;
        end else if (stat_i.zero) begin
          state_d = StDivGo;
        end else if (stat_i.is_buy) begin
          if (!stat_i.full) begin
            cmd_o.buy = 1'b1;
            state_d = StBuyAdd;
          end
        end else if (!stat_i.avg_mode) begin
          cmd_o.sell_init = 1'b1;
          state_d = StSellRd;
        end
      end
      StBuyAdd: begin
        cmd_o.add = 1'b1;
        state_d = StDivGo;
      end
      StSellRd: begin
        if (stat_i.want_zero || stat_i.count_zero) begin
          state_d = StDivGo;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = StSellMul;
        end
      end
      StSellMul: begin
        cmd_o.mul_sell = 1'b1;
        state_d = StSellSub;
      end
      StSellSub: begin
        cmd_o.sub_sell = 1'b1;
        state_d = StSellRd;
      end
      StDivGo: begin
        cmd_o.div_start = 1'b1;
        state_d = StDivRun;
      end
      StDivRun: begin
        if (!stat_i.div_busy) state_d = StOut;
      end
      StOut: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== rtl/core/cblm_div.sv =====
// restoring divider, one quotient bit per cycle
module cblm_div import cblm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [CostW-1:0]      dividend_i,
  input  logic [TotSharesW-1:0] divisor_i,
  output logic                  busy_o,
  output logic [CostW-1:0]      quotient_o
);
  localparam int CntW = $clog2(CostW + 1);

  logic [TotSharesW-1:0] rem_q, rem_d;
  logic [TotSharesW-1:0] dvs_q;
  logic [CostW-1:0]      quo_q, quo_d;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic [TotSharesW:0]   trial;
  logic                  fits;

  always_comb begin
    trial = {rem_q, quo_q[CostW-1]};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? TotSharesW'(trial - {1'b0, dvs_q}) : trial[TotSharesW-1:0];
    quo_d = {quo_q[CostW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(CostW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule

// ===== rtl/core/cblm_dp.sv =====
// datapath: config registers, lot ring memory, totals, multiplier and result register
module cblm_dp import cblm_pkg::*; #(
  parameter int MaxLots = MaxLotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_index_i,
  input  logic [DateW-1:0]      cfg_data_i,
  input  logic                  in_func_i,
  input  logic [DateW-1:0]      in_date_i,
  input  logic [SharesW-1:0]    in_shares_i,
  input  logic [PriceW-1:0]     in_price_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [PriceW-1:0]     avg_price_o,
  output logic                  has_position_o,
  output logic [TotSharesW-1:0] open_shares_o
);
  localparam int IdxW = (MaxLots > 1) ? $clog2(MaxLots) : 1;
  localparam int CntW = $clog2(MaxLots + 1);
  localparam int SumW = CntW + 1;

  logic [SharesW-1:0] lot_shares_mem [MaxLots];
  logic [PriceW-1:0]  lot_price_mem  [MaxLots];

  logic [ModeW-1:0]      cost_mode_q;
  logic [DateW-1:0]      calc_date_q;
  logic [IdxW-1:0]       head_q;
  logic [CntW-1:0]       count_q;
  logic [TotSharesW-1:0] share_q;
  logic [CostW-1:0]      cost_q;
  logic                  past_q;
  logic                  out_valid_q;

  logic                  func_q;
  logic [DateW-1:0]      date_q;
  logic [SharesW-1:0]    shares_q;
  logic [PriceW-1:0]     price_q;
  logic [SharesW-1:0]    want_q, have_q, take_q;
  logic [PriceW-1:0]     pr_q;
  logic [CostW-1:0]      prod_q;
  logic                  whole_q;
  logic [PriceW-1:0]     avg_q;
  logic [TotSharesW-1:0] open_q;

  logic [SumW-1:0]       tail_sum, last_sum;
  logic [IdxW-1:0]       tail_idx, last_idx, sel_idx, head_next;
  logic                  newest;
  logic [TotSharesW:0]   sh_add;
  logic [CostW:0]        cost_add;
  logic [CostW-1:0]      quotient;
  logic                  div_busy;

  function automatic logic [IdxW-1:0] wrap(input logic [SumW-1:0] s);
    logic [SumW-1:0] r;
    r = (s >= SumW'(MaxLots)) ? s - SumW'(MaxLots) : s;
    return r[IdxW-1:0];
  endfunction

  assign newest    = (cost_mode_q == ModeLifo);
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign last_sum  = tail_sum - 1'b1;
  assign tail_idx  = wrap(tail_sum);
  assign last_idx  = wrap(last_sum);
  assign sel_idx   = newest ? last_idx : head_q;
  assign head_next = wrap(SumW'(head_q) + 1'b1);
  assign sh_add    = {1'b0, share_q} + (TotSharesW+1)'(take_q);
  assign cost_add  = {1'b0, cost_q} + {1'b0, prod_q};

  always_comb begin
    stat_o            = '0;
    stat_o.is_new     = (func_q == FuncNew);
    stat_o.past       = past_q;
    stat_o.late       = (date_q > calc_date_q);
    stat_o.zero       = (shares_q == '0);
    stat_o.is_buy     = !shares_q[SharesW-1];
    stat_o.full       = (count_q == CntW'(MaxLots));
    stat_o.avg_mode   = cost_mode_q[1];
    stat_o.want_zero  = (want_q == '0);
    stat_o.count_zero = (count_q == '0);
    stat_o.div_busy   = div_busy;
    stat_o.out_busy   = out_valid_q && !m_ready_i;
  end

  cblm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cost_q),
    .divisor_i  (share_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_mode_q <= ModeFifo;
      calc_date_q <= '1;
      head_q      <= '0;
      count_q     <= '0;
      share_q     <= '0;
      cost_q      <= '0;
      past_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegCostMode) cost_mode_q <= cfg_data_i[ModeW-1:0];
        else calc_date_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        head_q  <= '0;
        count_q <= '0;
        share_q <= '0;
        cost_q  <= '0;
        past_q  <= 1'b0;
      end
      if (cmd_i.set_past) past_q <= 1'b1;
      if (cmd_i.add) begin
        share_q <= sh_add[TotSharesW] ? '1 : sh_add[TotSharesW-1:0];
        cost_q  <= cost_add[CostW] ? '1 : cost_add[CostW-1:0];
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.sub_sell) begin
        share_q <= (TotSharesW'(take_q) > share_q) ? '0 : share_q - TotSharesW'(take_q);
        cost_q  <= (prod_q > cost_q) ? '0 : cost_q - prod_q;
        if (whole_q) begin
          count_q <= count_q - 1'b1;
          if (!newest) head_q <= head_next;
        end
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers and lot memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q   <= in_func_i;
      date_q   <= in_date_i;
      shares_q <= in_shares_i;
      price_q  <= in_price_i;
    end
    if (cmd_i.buy) begin
      lot_shares_mem[tail_idx] <= shares_q;
      lot_price_mem[tail_idx]  <= price_q;
      prod_q <= CostW'(shares_q) * CostW'(price_q);
      take_q <= shares_q;
    end
    if (cmd_i.sell_init) want_q <= SharesW'(0) - shares_q;
    if (cmd_i.rd) begin
      have_q <= lot_shares_mem[sel_idx];
      pr_q   <= lot_price_mem[sel_idx];
    end
    if (cmd_i.mul_sell) begin
      whole_q <= (have_q <= want_q);
      take_q  <= (have_q <= want_q) ? have_q : want_q;
      prod_q  <= CostW'((have_q <= want_q) ? have_q : want_q) * CostW'(pr_q);
    end
    if (cmd_i.sub_sell) begin
      if (whole_q) begin
        want_q <= want_q - have_q;
      end else begin
        lot_shares_mem[sel_idx] <= have_q - want_q;
        want_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      open_q <= share_q;
      if (share_q == '0) avg_q <= '0;
      else if (|quotient[CostW-1:PriceW]) avg_q <= '1;
      else avg_q <= quotient[PriceW-1:0];
    end
  end

  assign m_valid_o      = out_valid_q;
  assign avg_price_o    = avg_q;
  assign open_shares_o  = open_q;
  assign has_position_o = (open_q != '0);
endmodule

// ===== sim/cost_basis_lot_matcher_checker.sv =====
// checker for the cost basis lot matcher: watches the channels, predicts and compares
`timescale 1ns / 100ps
module cost_basis_lot_matcher_checker import cblm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [DateW-1:0]    cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);
  localparam int Lots = MaxLotsDef;
  localparam logic [TotSharesW-1:0] ShareSat = '1;
  localparam logic [CostW-1:0]      CostSat  = '1;

  typedef struct packed {
    logic [PriceW-1:0]     avg;
    logic                  has_pos;
    logic [TotSharesW-1:0] shares;
  } position_t;

  logic [SharesW-1:0]    lot_qty [Lots];
  logic [PriceW-1:0]     lot_px  [Lots];
  int                    head, count;
  logic [TotSharesW-1:0] shares_held;
  logic [CostW-1:0]      cost_held;
  logic                  stale;
  logic [ModeW-1:0]      mode;
  logic [DateW-1:0]      cutoff;
  position_t             expected_positions [$];

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors_o++;
  endtask

  function automatic void take_out(input logic [63:0] sh, input logic [63:0] cost);
    shares_held = (sh > {24'd0, shares_held}) ? '0 : shares_held - sh[TotSharesW-1:0];
    cost_held   = (cost > cost_held) ? '0 : cost_held - cost;
  endfunction

  function automatic void apply_trade(input logic [DateW-1:0] d, input logic [SharesW-1:0] q,
                                      input logic [PriceW-1:0] px);
    logic [63:0]        want, have, sum;
    logic [64:0]        csum;
    logic [SharesW-1:0] neg;
    int                 slot;
    bit                 newest;
    if (stale) return;
    if (d > cutoff) begin
      stale = 1'b1;
      return;
    end
    if (q == '0) return;
    if (!q[SharesW-1]) begin
      if (count >= Lots) return;
      slot = (head + count) % Lots;
      lot_qty[slot] = q;
      lot_px[slot] = px;
      count++;
      sum = {24'd0, shares_held} + q;
      shares_held = (sum > {24'd0, ShareSat}) ? ShareSat : sum[TotSharesW-1:0];
      csum = {1'b0, cost_held} + 64'(q) * 64'(px);
      cost_held = csum[64] ? CostSat : csum[63:0];
      return;
    end
    if (mode >= 2) return;
    newest = (mode == ModeLifo);
    // sell size as a 32-bit magnitude
    neg = '0 - q;
    want = {32'd0, neg};
    while (want != 0 && count != 0) begin
      slot = newest ? (head + count - 1) % Lots : head;
      have = lot_qty[slot];
      if (have <= want) begin
        want -= have;
        take_out(have, have * lot_px[slot]);
        if (!newest) head = (head + 1) % Lots;
        count--;
      end else begin
        lot_qty[slot] = SharesW'(have - want);
        take_out(want, want * lot_px[slot]);
        want = 0;
      end
    end
  endfunction

  function automatic position_t current_position();
    position_t   p;
    logic [63:0] q;
    q = (shares_held != 0) ? cost_held / shares_held : '0;
    p.avg = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
    p.has_pos = shares_held != 0;
    p.shares = shares_held;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    position_t got, exp;
    if (!rst_ni) begin
      head = 0; count = 0; shares_held = '0; cost_held = '0; stale = 1'b0;
      mode = ModeFifo; cutoff = '1;
      expected_positions.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegCostMode) mode = cfg_data_i[ModeW-1:0];
        else cutoff = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.avg = m_axis_tdata[31:0];
        got.shares = m_axis_tdata[71:32];
        got.has_pos = m_axis_tuser;
        if (expected_positions.size() == 0) report("result with none expected");
        else begin
          exp = expected_positions.pop_front();
          if (got.avg !== exp.avg)
            report($sformatf("avg_price %0h want %0h", got.avg, exp.avg));
          if (got.has_pos !== exp.has_pos)
            report($sformatf("has_position %0b want %0b", got.has_pos, exp.has_pos));
          if (got.shares !== exp.shares)
            report($sformatf("open_shares %0h want %0h", got.shares, exp.shares));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FuncNew) begin
          head = 0; count = 0; shares_held = '0; cost_held = '0; stale = 1'b0;
        end else
          apply_trade(s_axis_tdata[19:0], s_axis_tdata[51:20], s_axis_tdata[83:52]);
        expected_positions.push_back(current_position());
      end
    end
    pending_o = expected_positions.size();
  end
endmodule

// ===== sim/cost_basis_lot_matcher_test.sv =====
// testbench top for the cost basis lot matcher: stimulus and verdict
`timescale 1ns / 100ps
module cost_basis_lot_matcher_test;
  import cblm_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = 1'b0;
  logic [DateW-1:0]    cfg_data_i = '0;
  int                  errors, pending;
  int                  send_idle_pct, recv_idle_pct;
  bit                  hold_off;
  int                  idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  cost_basis_lot_matcher u_top (.*);

  cost_basis_lot_matcher_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls at random, or for a long stretch when hold_off is set
  always @(posedge clk_i) begin
    int n;
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      for (n = 0; n < 3000; n++) @(posedge clk_i);
      hold_off = 1'b0;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("cost_basis_lot_matcher_test: errors");
      $finish;
    end
  end

  task automatic send_request(input logic func, input logic [19:0] d,
                              input logic [31:0] q, input logic [31:0] px);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'd0, px, q, d};
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly buy/sell runs with modest sizes, some huge values and noise
  task automatic random_trade(input logic [19:0] dmax);
    logic [31:0] q, px;
    int          r;
    r = $urandom_range(99);
    if (r < 2) begin
      send_request(FuncNew, 20'($urandom), $urandom, $urandom);
      return;
    end
    q  = (r < 10) ? $urandom : $urandom_range(1, 5000);
    px = (r < 15) ? $urandom : $urandom_range(1, 2000000);
    if ($urandom_range(99) < 40) q = -$urandom_range(1, 12000);
    if (r < 12 && $urandom_range(1)) q = -q;
    if ($urandom_range(99) < 3) q = '0;
    send_request(1'b0, 20'($urandom_range(0, dmax)), q, px);
  endtask

  initial begin
    int i, ph;
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, buys, FIFO and LIFO sells, oversell, zero, full store, late trade, modes 2 and 3
    send_request(1'b0, 20'd5, 32'd1000, 32'd250000);
    send_request(1'b0, '1, 32'h7FFF_FFFF, '1);
    send_request(1'b0, 20'd0, 32'd2000, 32'd0);
    send_request(1'b0, 20'd7, 32'd0, 32'd5);
    send_request(1'b0, 20'd8, -32'd1500, 32'd1);
    send_request(1'b0, 20'd9, 32'h8000_0000, '1);
    send_request(1'b0, 20'd9, 32'h8000_0000, '1);
    for (i = 0; i < 66; i++) send_request(1'b0, 20'd10, 32'h7FFF_FFFF, '1);
    send_request(FuncNew, '1, '1, '1);
    drain();
    write_reg(RegCostMode, 20'(ModeLifo));
    write_reg(RegCalcDate, 20'd100);
    send_request(1'b0, 20'd1, 32'd3000, 32'd100);
    send_request(1'b0, 20'd2, 32'd1000, 32'd900);
    send_request(1'b0, 20'd3, -32'd1500, 32'd0);
    send_request(1'b0, 20'd101, 32'd50, 32'd50);
    send_request(1'b0, 20'd4, 32'd50, 32'd50);
    send_request(FuncNew, 20'd0, 32'd0, 32'd0);
    drain();
    write_reg(RegCostMode, 20'd2);
    write_reg(RegCalcDate, 20'd0);
    send_request(1'b0, 20'd0, 32'd700, 32'd30);
    send_request(1'b0, 20'd0, -32'd300, 32'd30);
    drain();
    write_reg(RegCostMode, 20'd3);
    send_request(1'b0, 20'd0, -32'd10, 32'd30);
    send_request(FuncNew, 20'd0, 32'd0, 32'd0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 23; recv_idle_pct = 56; end
        1: begin send_idle_pct = 56; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(RegCostMode, 20'(ph % 4));
      write_reg(RegCalcDate, (ph == 5) ? 20'hFFFFF : 20'($urandom_range(900000, 1048575)));
      if (ph == 2) hold_off = 1'b1;
      for (i = 0; i < 265; i++) random_trade((ph == 4) ? 20'hFFFFF : 20'd900000);
      drain();
    end

    if (errors == 0) $display("cost_basis_lot_matcher_test: clean");
    else $display("cost_basis_lot_matcher_test: errors");
    $finish;
  end
endmodule
